[rtl/fhf_pkg.sv]
// ----------------------------------------------------------------------------
// fhf_pkg: shared types and constants of the fire heat field update unit
// Widths, blur weights, reset values and the controller/datapath interface.
// ----------------------------------------------------------------------------
package fhf_pkg;

	localparam int COORD_W          = 3;
	localparam int HEAT_W           = 8;
	localparam int SUM_W            = 16;   // sum wraps mod 65536 by width
	localparam int FRAME_WIDTH_DEF  = 8;
	localparam int FRAME_HEIGHT_DEF = 8;
	localparam int SPARK_HEAT_RST   = 8;

	// blur weights
	localparam int W_SELF  = 127;
	localparam int W_SIDE  = 31;
	localparam int W_ABOVE = 7;
	localparam int W_BELOW = 63;

	typedef struct packed {
		logic start;   // load spark column, reset sweep position
		logic spk_rd;  // read bottom pixel of spark column
		logic spk_wr;  // write saturated spark value back
		logic rd1;     // read self and right
		logic rd2;     // read above and below
		logic calc;    // compute, write back, load output, advance
	} fhf_cmd_t;

	typedef struct packed {
		logic out_free;  // output register can take a pixel this cycle
		logic last;      // current pixel is the final one of the sweep
	} fhf_sts_t;

endpackage

[rtl/fire_heat_field_update_unit.sv]
// ----------------------------------------------------------------------------
// fire_heat_field_update_unit: fire effect heat store with in-place blur
// Spark injection into the bottom row, then one blur sweep per frame tick.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, spark_column): one transfer per frame
//    tick. spark_heat is added, saturating, to the bottom pixel of that column
//    (columns at or beyond FRAME_WIDTH get no spark), then the frame is blurred.
//  - Output channel (out_valid/out_ready): one transfer per pixel, bottom row
//    first, left to right, FRAME_WIDTH*FRAME_HEIGHT transfers per tick;
//    last_pixel marks the top-right pixel.
//  - cfg_wr_en/cfg_wr_data write spark_heat (reset value 8); write only idle.
//  - First pixel: after spark read, spark write, its two reads and its compute.
//  - Sequence: spark read and spark write, then per pixel two read steps and
//    one compute/write step; a new tick is taken only back in idle. The heat
//    store has two read ports and each pixel needs four stored values (self,
//    right, above, below), so two read steps plus one compute/write step.
//  - Receiver stall: the output register holds its pixel and the sweep waits
//    in the compute step; nothing is dropped.
//  - Reset: heat store reads as all zero (per-entry valid bits), sequencer
//    idle, no output pending.
// ----------------------------------------------------------------------------
module fire_heat_field_update_unit import fhf_pkg::*; #(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] spark_column,
	input  logic               cfg_wr_en,
	input  logic [HEAT_W-1:0]  cfg_wr_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COORD_W-1:0] pixel_column,
	output logic [COORD_W-1:0] pixel_row,
	output logic [HEAT_W-1:0]  heat_value,
	output logic               last_pixel
);

	fhf_cmd_t cmd;
	fhf_sts_t sts;

	// sequencer: spark read, spark write, then read/read/compute per pixel
	fhf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// heat store, neighbor registers, weighted sum, output register
	fhf_dp #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.spark_column (spark_column),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.heat_value   (heat_value),
		.last_pixel   (last_pixel)
	);

`ifndef ASSERT_OFF
	// a tick transfer starts a sweep; no second tick is taken the next cycle
	ap_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a tick transfer");

	// pixels are only produced when the output register can take them
	ap_calc_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc |-> sts.out_free)
		else $error("pixel computed while output register is blocked");

	// the end-of-sweep mark sits only on the top-right pixel
	ap_last_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |->
			pixel_row == '0 && pixel_column == COORD_W'(FRAME_WIDTH - 1))
		else $error("last pixel flag on wrong position");
`endif

endmodule

[rtl/fhf_ctrl.sv]
// ----------------------------------------------------------------------------
// fhf_ctrl: sequencer of the heat field update
// Steps spark read/write, then two reads and a compute per pixel across the frame.
// ----------------------------------------------------------------------------
module fhf_ctrl import fhf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  fhf_sts_t sts,
	output fhf_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SPK_RD = 6'b000010,
		ST_SPK_WR = 6'b000100,
		ST_RD1    = 6'b001000,
		ST_RD2    = 6'b010000,
		ST_CALC   = 6'b100000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_SPK_RD;
			end
			ST_SPK_RD: state_nxt = ST_SPK_WR;
			ST_SPK_WR: state_nxt = ST_RD1;
			ST_RD1:    state_nxt = ST_RD2;
			ST_RD2:    state_nxt = ST_CALC;
			ST_CALC: begin
				if (sts.out_free) state_nxt = sts.last ? ST_IDLE : ST_RD1;
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.start  = (state_q == ST_IDLE) && in_valid;
	assign cmd.spk_rd = (state_q == ST_SPK_RD);
	assign cmd.spk_wr = (state_q == ST_SPK_WR);
	assign cmd.rd1    = (state_q == ST_RD1);
	assign cmd.rd2    = (state_q == ST_RD2);
	assign cmd.calc   = (state_q == ST_CALC) && sts.out_free;

endmodule

[rtl/fhf_dp.sv]
// ----------------------------------------------------------------------------
// fhf_dp: heat store, neighbor fetch, weighted blur and output register
// Two read ports and one write port on the store; valid bits give reset zero.
// ----------------------------------------------------------------------------
module fhf_dp import fhf_pkg::*; #(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fhf_cmd_t           cmd,
	output fhf_sts_t           sts,
	input  logic [COORD_W-1:0] spark_column,
	input  logic               cfg_wr_en,
	input  logic [HEAT_W-1:0]  cfg_wr_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COORD_W-1:0] pixel_column,
	output logic [COORD_W-1:0] pixel_row,
	output logic [HEAT_W-1:0]  heat_value,
	output logic               last_pixel
);

	localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [COORD_W-1:0] X_LAST = COORD_W'(FRAME_WIDTH - 1);
	localparam logic [COORD_W-1:0] Y_LAST = COORD_W'(FRAME_HEIGHT - 1);

	function automatic logic [ADDR_W-1:0] idx(input logic [COORD_W-1:0] yy,
	                                          input logic [COORD_W-1:0] xx);
		return ADDR_W'(yy) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(xx);
	endfunction

	logic [HEAT_W-1:0]  mem_q [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic [HEAT_W-1:0]  spark_heat_q;
	logic [COORD_W-1:0] spk_col_q, x_q, y_q;
	logic [HEAT_W-1:0]  rdat_a_q, rdat_b_q, self_q, right_q, left_q;
	logic               rvld_a_q, rvld_b_q;
	logic               out_valid_q, last_q;
	logic [COORD_W-1:0] col_q, row_q;
	logic [HEAT_W-1:0]  heat_q;

	logic [ADDR_W-1:0]  addr_a, addr_b, waddr, self_addr, spk_addr;
	logic               rd_en, we, spark_ok, x_end, y_top, y_bot;
	logic [HEAT_W-1:0]  rd_a, rd_b, wdata, new_val;
	logic [HEAT_W-1:0]  t_left, t_right, t_above, t_below;
	logic [HEAT_W:0]    spk_sum;
	logic [SUM_W-1:0]   sum;

	assign x_end     = (x_q == X_LAST);
	assign y_top     = (y_q == '0);
	assign y_bot     = (y_q == Y_LAST);
	assign spark_ok  = ({1'b0, spk_col_q} < (COORD_W + 1)'(FRAME_WIDTH));
	assign self_addr = idx(y_q, x_q);
	assign spk_addr  = spark_ok ? idx(Y_LAST, spk_col_q) : '0;

	assign rd_a = rvld_a_q ? rdat_a_q : '0;
	assign rd_b = rvld_b_q ? rdat_b_q : '0;

	// read address selection; missing neighbors fall back to self, later zeroed (below: self)
	always_comb begin
		addr_a = self_addr;
		addr_b = self_addr;
		if (cmd.spk_rd) begin
			addr_a = spk_addr;
		end else if (cmd.rd1) begin
			addr_b = x_end ? self_addr : idx(y_q, x_q + 1'b1);
		end else if (cmd.rd2) begin
			addr_a = y_top ? self_addr : idx(y_q - 1'b1, x_q);
			addr_b = y_bot ? self_addr : idx(y_q + 1'b1, x_q);
		end
	end

	assign rd_en = cmd.spk_rd || cmd.rd1 || cmd.rd2;

	// spark: saturating add
	assign spk_sum = {1'b0, rd_a} + {1'b0, spark_heat_q};

	// blur terms; left is the pixel just written, below came back updated
	assign t_left  = (x_q == '0) ? '0 : left_q;
	assign t_right = x_end ? '0 : right_q;
	assign t_above = y_top ? '0 : rd_a;
	assign t_below = y_bot ? self_q : rd_b;
	assign sum = SUM_W'(self_q)  * SUM_W'(W_SELF)
	           + SUM_W'(t_left)  * SUM_W'(W_SIDE)
	           + SUM_W'(t_right) * SUM_W'(W_SIDE)
	           + SUM_W'(t_above) * SUM_W'(W_ABOVE)
	           + SUM_W'(t_below) * SUM_W'(W_BELOW);
	assign new_val = sum[SUM_W-1:SUM_W-HEAT_W];

	assign we    = (cmd.spk_wr && spark_ok) || cmd.calc;
	assign waddr = cmd.calc ? self_addr : spk_addr;
	assign wdata = cmd.calc ? new_val : (spk_sum[HEAT_W] ? '1 : spk_sum[HEAT_W-1:0]);

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdat_a_q <= mem_q[addr_a];
			rdat_b_q <= mem_q[addr_b];
			rvld_a_q <= vld_q[addr_a];
			rvld_b_q <= vld_q[addr_b];
		end
		if (cmd.rd2) begin
			self_q  <= rd_a;
			right_q <= rd_b;
		end
		if (cmd.calc) left_q <= new_val;
		if (cmd.start) spk_col_q <= spark_column;
		if (cmd.calc) begin
			col_q  <= x_q;
			row_q  <= y_q;
			heat_q <= new_val;
			last_q <= x_end && y_top;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q        <= '0;
			spark_heat_q <= HEAT_W'(SPARK_HEAT_RST);
			x_q          <= '0;
			y_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (we) vld_q[waddr] <= 1'b1;
			if (cfg_wr_en) spark_heat_q <= cfg_wr_data;
			if (cmd.start) begin
				x_q <= '0;
				y_q <= Y_LAST;
			end else if (cmd.calc) begin
				if (x_end) begin
					x_q <= '0;
					y_q <= y_q - 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			if (cmd.calc) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.last     = x_end && y_top;

	assign out_valid    = out_valid_q;
	assign pixel_column = col_q;
	assign pixel_row    = row_q;
	assign heat_value   = heat_q;
	assign last_pixel   = last_q;

endmodule
